>>> rtl/mnsh_pkg.sv
// Package for the majority node structural hash block.
// Holds widths, key constants, status and request codes, and the control structs.
// Used by every module of the block but mnsh_ram; depends on nothing.
package mnsh_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int BUCKETS_DEF   = 1024;
    localparam int WAYS_DEF      = 4;

    localparam int ID_W   = 12;
    localparam int LV_W   = 12;
    localparam int ST_W   = 3;
    localparam int REQ_W  = 2;
    localparam int TS_W   = 11;
    localparam int OCNT_W = 13;
    localparam int KEY_W  = 27;

    localparam int TSIZE_RESET = 1024;

    localparam logic [KEY_W-1:0] K_A  = KEY_W'(23813);
    localparam logic [KEY_W-1:0] K_B  = KEY_W'(7937);
    localparam logic [KEY_W-1:0] K_C  = KEY_W'(2971);
    localparam logic [KEY_W-1:0] K_NA = KEY_W'(911);
    localparam logic [KEY_W-1:0] K_NB = KEY_W'(353);
    localparam logic [KEY_W-1:0] K_NC = KEY_W'(113);

    localparam logic [LV_W-1:0] LEVEL_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SPARE  = 2'd3;

    localparam logic [ST_W-1:0] ST_TRIVIAL   = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [ST_W-1:0] ST_CREATED   = 3'd2;
    localparam logic [ST_W-1:0] ST_MISS      = 3'd3;
    localparam logic [ST_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [ST_W-1:0] ST_DEL_MISS  = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd6;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd7;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_FIRST_FREE = 1'b1;

    typedef struct packed {
        logic ready;
        logic capture;
        logic clr_wr;
        logic mul_step;
        logic div_step;
        logic way_rd;
        logic way_chk;
        logic lv_rd;
        logic lv_chk;
        logic ins_wr;
        logic del_rd;
        logic del_chk;
        logic fin;
        logic cnt_clr;
        logic cnt_inc;
    } t_cmd;

    typedef struct packed {
        logic del;
        logic triv;
        logic last;
        logic match;
        logic hit;
        logic can_create;
        logic make;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/mnsh_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module mnsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mnsh_datapath.sv
// Datapath of the majority node structural hash: literal sorting, key, modulo,
// bucket and level memories, counters and the result register.
// Depends on mnsh_pkg and mnsh_ram.
module mnsh_datapath #(
    parameter int MAX_NODES = mnsh_pkg::MAX_NODES_DEF,
    parameter int BUCKETS   = mnsh_pkg::BUCKETS_DEF,
    parameter int WAYS      = mnsh_pkg::WAYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mnsh_pkg::t_cmd               i_cmd,
    output mnsh_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [mnsh_pkg::ID_W-1:0]    i_cfg_data,
    input  logic [mnsh_pkg::REQ_W-1:0]   i_req_type,
    input  logic [mnsh_pkg::ID_W-1:0]    i_id_a,
    input  logic                         i_neg_a,
    input  logic [mnsh_pkg::ID_W-1:0]    i_id_b,
    input  logic                         i_neg_b,
    input  logic [mnsh_pkg::ID_W-1:0]    i_id_c,
    input  logic                         i_neg_c,
    input  logic [mnsh_pkg::ID_W-1:0]    i_victim_id,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [mnsh_pkg::ST_W-1:0]    o_status,
    output logic [mnsh_pkg::ID_W-1:0]    o_out_id,
    output logic                         o_out_neg,
    output logic [mnsh_pkg::LV_W-1:0]    o_out_level,
    output logic [mnsh_pkg::OCNT_W-1:0]  o_stored_count
);
    localparam int ID_W   = mnsh_pkg::ID_W;
    localparam int LV_W   = mnsh_pkg::LV_W;
    localparam int KEY_W  = mnsh_pkg::KEY_W;
    localparam int NXW    = ($clog2(MAX_NODES + 1) > ID_W) ? $clog2(MAX_NODES + 1) : ID_W;
    localparam int LAW    = $clog2(MAX_NODES);
    localparam int ENT    = BUCKETS * WAYS;
    localparam int AW     = $clog2(ENT);
    localparam int EW     = 1 + 3 * ID_W + 3 + NXW;
    localparam int SW     = $clog2(BUCKETS + 1);
    localparam int CLR_N  = (ENT > MAX_NODES) ? ENT : MAX_NODES;
    localparam int CNT_MX = (CLR_N > KEY_W) ? CLR_N : KEY_W;
    localparam int CW     = $clog2(CNT_MX + 1);
    localparam int TW     = ($clog2(ENT + 1) > mnsh_pkg::OCNT_W) ? $clog2(ENT + 1)
                                                                 : mnsh_pkg::OCNT_W;

    logic [mnsh_pkg::TS_W-1:0]  r_tsize;
    logic [NXW-1:0]             r_next_id;
    logic [TW-1:0]              r_total;
    logic [CW-1:0]              r_cnt;
    logic [mnsh_pkg::REQ_W-1:0] r_req;
    logic [ID_W-1:0]            r_f [3];
    logic                       r_n [3];
    logic [ID_W-1:0]            r_victim;
    logic                       r_del;
    logic                       r_triv;
    logic [ID_W-1:0]            r_tid;
    logic                       r_tneg;
    logic [KEY_W-1:0]           r_key;
    logic [SW-1:0]              r_rem;
    logic                       r_free_vld;
    logic [AW-1:0]              r_free;
    logic                       r_hit;
    logic [NXW-1:0]             r_hit_node;
    logic                       r_del_found;
    logic                       r_loob;
    logic [LV_W-1:0]            r_lvmax;
    logic                       r_created;
    logic [NXW-1:0]             r_new_id;
    logic [LV_W-1:0]            r_new_lv;
    logic                       r_ovalid;
    logic [mnsh_pkg::ST_W-1:0]  r_ost;
    logic [ID_W-1:0]            r_oid;
    logic                       r_oneg;
    logic [LV_W-1:0]            r_olv;
    logic [mnsh_pkg::OCNT_W-1:0] r_ocnt;

    logic [ID_W-1:0]  s_a, s_b, s_c, t_id;
    logic             s_na, s_nb, s_nc, t_sw;
    logic             c_triv;
    logic [ID_W-1:0]  c_tid;
    logic             c_tneg;
    logic [SW-1:0]    c_size;
    logic [SW:0]      c_div;
    logic [KEY_W-1:0] c_kc, c_prod;
    logic [AW-1:0]    c_base;
    logic [EW-1:0]    b_rdata, b_wdata;
    logic [AW-1:0]    b_raddr, b_waddr;
    logic             b_we;
    logic [LV_W-1:0]  l_rdata, l_wdata;
    logic [LAW-1:0]   l_raddr, l_waddr;
    logic             l_we;
    logic [NXW-1:0]   c_lid;
    logic             e_valid;
    logic [NXW-1:0]   e_node;
    logic             c_wmatch, c_dmatch, c_make, c_exh;
    logic [LV_W-1:0]  c_lv, c_newlv;
    logic [mnsh_pkg::ST_W-1:0] c_st;
    logic [ID_W-1:0]  c_oid;
    logic [LV_W-1:0]  c_olv;

    // Trivial reductions, in priority order.
    always_comb begin
        c_triv = 1'b1;
        c_tid  = i_id_a;
        c_tneg = i_neg_a;
        if (i_id_a == i_id_b && i_neg_a == i_neg_b) begin
            c_tid = i_id_a; c_tneg = i_neg_a;
        end else if (i_id_a == i_id_c && i_neg_a == i_neg_c) begin
            c_tid = i_id_a; c_tneg = i_neg_a;
        end else if (i_id_b == i_id_c && i_neg_b == i_neg_c) begin
            c_tid = i_id_b; c_tneg = i_neg_b;
        end else if (i_id_a == i_id_b) begin
            c_tid = i_id_c; c_tneg = i_neg_c;
        end else if (i_id_a == i_id_c) begin
            c_tid = i_id_b; c_tneg = i_neg_b;
        end else if (i_id_b == i_id_c) begin
            c_tid = i_id_a; c_tneg = i_neg_a;
        end else begin
            c_triv = 1'b0;
        end
    end

    // Three compare-exchange steps sort the literals by id.
    always_comb begin
        s_a = i_id_a; s_na = i_neg_a;
        s_b = i_id_b; s_nb = i_neg_b;
        s_c = i_id_c; s_nc = i_neg_c;
        if (s_a > s_b) begin
            t_id = s_a; s_a = s_b; s_b = t_id;
            t_sw = s_na; s_na = s_nb; s_nb = t_sw;
        end
        if (s_b > s_c) begin
            t_id = s_b; s_b = s_c; s_c = t_id;
            t_sw = s_nb; s_nb = s_nc; s_nc = t_sw;
        end
        if (s_a > s_b) begin
            t_id = s_a; s_a = s_b; s_b = t_id;
            t_sw = s_na; s_na = s_nb; s_nb = t_sw;
        end
        t_id = '0;
        t_sw = 1'b0;
    end

    always_comb begin
        if (r_tsize == '0) begin
            c_size = SW'(1);
        end else if (32'(r_tsize) > BUCKETS) begin
            c_size = SW'(BUCKETS);
        end else begin
            c_size = SW'(r_tsize);
        end
        case (r_cnt[1:0])
            2'd0:    c_kc = mnsh_pkg::K_A;
            2'd1:    c_kc = mnsh_pkg::K_B;
            default: c_kc = mnsh_pkg::K_C;
        endcase
        c_prod = KEY_W'(r_f[r_cnt[1:0]]) * c_kc;
        c_div  = {r_rem, r_key[KEY_W-1]};
        if (c_div >= {1'b0, c_size}) begin
            c_div = c_div - {1'b0, c_size};
        end
        c_base = AW'(r_rem) * AW'(WAYS);
    end

    assign e_valid  = b_rdata[EW-1];
    assign e_node   = b_rdata[NXW-1:0];
    assign c_wmatch = e_valid && b_rdata[EW-2 -: 3*ID_W+3] ==
                      {r_f[0], r_f[1], r_f[2], r_n[0], r_n[1], r_n[2]};
    assign c_dmatch = e_valid && e_node == NXW'(r_victim);
    assign c_make   = !r_del && !r_triv && !r_hit;
    assign c_exh    = 32'(r_next_id) >= MAX_NODES;

    always_comb begin
        if (r_del) begin
            c_lid = NXW'(r_victim);
        end else if (r_triv) begin
            c_lid = NXW'(r_tid);
        end else if (r_hit) begin
            c_lid = r_hit_node;
        end else begin
            c_lid = NXW'(r_f[r_cnt[1:0]]);
        end
        c_lv    = r_loob ? '0 : l_rdata;
        c_newlv = (r_lvmax >= mnsh_pkg::LEVEL_MAX) ? mnsh_pkg::LEVEL_MAX : r_lvmax + 1'b1;
    end

    always_comb begin
        b_we    = 1'b0;
        b_waddr = r_cnt[AW-1:0];
        b_wdata = '0;
        if (i_cmd.clr_wr || (i_cmd.del_chk && c_dmatch)) begin
            b_we = 1'b1;
        end else if (i_cmd.ins_wr) begin
            b_we    = 1'b1;
            b_waddr = r_free;
            b_wdata = {1'b1, r_f[0], r_f[1], r_f[2], r_n[0], r_n[1], r_n[2], r_next_id};
        end
        b_raddr = i_cmd.way_rd ? c_base + r_cnt[AW-1:0] : r_cnt[AW-1:0];
        l_we    = i_cmd.clr_wr || i_cmd.ins_wr;
        l_waddr = i_cmd.ins_wr ? r_next_id[LAW-1:0] : r_cnt[LAW-1:0];
        l_wdata = i_cmd.ins_wr ? c_newlv : '0;
        l_raddr = c_lid[LAW-1:0];
    end

    mnsh_ram #(.WIDTH(EW), .DEPTH(ENT)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mnsh_ram #(.WIDTH(LV_W), .DEPTH(MAX_NODES)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        c_st  = mnsh_pkg::ST_MISS;
        c_oid = '0;
        c_olv = '0;
        if (r_del) begin
            c_st  = r_del_found ? mnsh_pkg::ST_DELETED : mnsh_pkg::ST_DEL_MISS;
            c_oid = r_victim;
            c_olv = r_del_found ? r_lvmax : '0;
        end else if (r_triv) begin
            c_st  = mnsh_pkg::ST_TRIVIAL;
            c_oid = r_tid;
            c_olv = r_lvmax;
        end else if (r_hit) begin
            c_st  = mnsh_pkg::ST_FOUND;
            c_oid = r_hit_node[ID_W-1:0];
            c_olv = r_lvmax;
        end else if (r_created) begin
            c_st  = mnsh_pkg::ST_CREATED;
            c_oid = r_new_id[ID_W-1:0];
            c_olv = r_new_lv;
        end else if (r_req != mnsh_pkg::REQ_CREATE) begin
            c_st = mnsh_pkg::ST_MISS;
        end else if (c_exh) begin
            c_st = mnsh_pkg::ST_EXHAUSTED;
        end else begin
            c_st = mnsh_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize   <= mnsh_pkg::TS_W'(mnsh_pkg::TSIZE_RESET);
            r_next_id <= NXW'(1);
            r_total   <= '0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == mnsh_pkg::CFG_TABLE_SIZE) begin
                    r_tsize <= i_cfg_data[mnsh_pkg::TS_W-1:0];
                end else begin
                    r_next_id <= NXW'(i_cfg_data);
                end
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_next_id <= r_next_id + 1'b1;
                r_total   <= r_total + 1'b1;
            end
            if (i_cmd.del_chk && c_dmatch && r_total != '0) begin
                r_total <= r_total - 1'b1;
            end
            if (i_cmd.fin) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req       <= i_req_type;
            r_del       <= i_req_type == mnsh_pkg::REQ_DELETE;
            r_triv      <= c_triv;
            r_tid       <= c_tid;
            r_tneg      <= c_tneg;
            r_victim    <= i_victim_id;
            r_f[0]      <= s_a; r_f[1] <= s_b; r_f[2] <= s_c;
            r_n[0]      <= s_na; r_n[1] <= s_nb; r_n[2] <= s_nc;
            r_key       <= (s_na ? mnsh_pkg::K_NA : '0) ^ (s_nb ? mnsh_pkg::K_NB : '0) ^
                           (s_nc ? mnsh_pkg::K_NC : '0);
            r_rem       <= '0;
            r_free_vld  <= 1'b0;
            r_free      <= '0;
            r_hit       <= 1'b0;
            r_hit_node  <= '0;
            r_del_found <= 1'b0;
            r_lvmax     <= '0;
            r_created   <= 1'b0;
        end
        if (i_cmd.mul_step) begin
            r_key <= r_key ^ c_prod;
        end
        if (i_cmd.div_step) begin
            r_rem <= SW'(c_div);
            r_key <= r_key << 1;
        end
        if (i_cmd.way_chk) begin
            if (c_wmatch) begin
                r_hit      <= 1'b1;
                r_hit_node <= e_node;
            end else if (!e_valid && !r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free     <= c_base + r_cnt[AW-1:0];
            end
        end
        if (i_cmd.del_chk && c_dmatch) begin
            r_del_found <= 1'b1;
        end
        if (i_cmd.lv_rd) begin
            r_loob <= 32'(c_lid) >= MAX_NODES;
        end
        if (i_cmd.lv_chk && c_lv > r_lvmax) begin
            r_lvmax <= c_lv;
        end
        if (i_cmd.ins_wr) begin
            r_created <= 1'b1;
            r_new_id  <= r_next_id;
            r_new_lv  <= c_newlv;
        end
        if (i_cmd.fin) begin
            r_ost <= c_st;
            r_oid <= c_oid;
            r_oneg <= r_triv && !r_del && r_tneg;
            r_olv <= c_olv;
            r_ocnt <= r_total[mnsh_pkg::OCNT_W-1:0];
        end
    end

    always_comb begin
        o_sts.del        = i_req_type == mnsh_pkg::REQ_DELETE;
        o_sts.triv       = c_triv;
        o_sts.match      = i_cmd.way_chk ? c_wmatch : c_dmatch;
        o_sts.hit        = r_hit;
        o_sts.can_create = r_req == mnsh_pkg::REQ_CREATE && !c_exh && r_free_vld;
        o_sts.make       = c_make;
        o_sts.out_free   = !r_ovalid || i_out_ready;
        if (i_cmd.clr_wr) begin
            o_sts.last = r_cnt == CW'(CLR_N - 1);
        end else if (i_cmd.mul_step) begin
            o_sts.last = r_cnt == CW'(2);
        end else if (i_cmd.div_step) begin
            o_sts.last = r_cnt == CW'(KEY_W - 1);
        end else if (i_cmd.way_chk) begin
            o_sts.last = r_cnt == CW'(WAYS - 1);
        end else if (i_cmd.del_chk) begin
            o_sts.last = r_cnt == CW'(ENT - 1);
        end else begin
            o_sts.last = !c_make || r_cnt == CW'(2);
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ost;
    assign o_out_id       = r_oid;
    assign o_out_neg      = r_oneg;
    assign o_out_level    = r_olv;
    assign o_stored_count = r_ocnt;

`ifndef NO_ASSERTIONS
    a_ins_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> (!r_hit && r_free_vld && !c_exh))
        else $error("insert without a free way or a fresh id");
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |=> r_total == $past(r_total) + 1'b1)
        else $error("insert did not count the new entry");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= ENT)
        else $error("stored count exceeds table capacity");
`endif
endmodule

>>> rtl/mnsh_ctrl.sv
// Controller of the majority node structural hash: sequences clearing, hashing,
// the bucket search, level reads and the result hand-off. Depends on mnsh_pkg.
module mnsh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mnsh_pkg::t_sts i_sts,
    output mnsh_pkg::t_cmd o_cmd
);
    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_MUL    = 13'b0000000000100,
        S_DIV    = 13'b0000000001000,
        S_WRD    = 13'b0000000010000,
        S_WCHK   = 13'b0000000100000,
        S_DECIDE = 13'b0000001000000,
        S_LRD    = 13'b0000010000000,
        S_LCHK   = 13'b0000100000000,
        S_INS    = 13'b0001000000000,
        S_DRD    = 13'b0010000000000,
        S_DCHK   = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    if (i_sts.del) begin
                        n_state = S_DRD;
                    end else if (i_sts.triv) begin
                        n_state = S_LRD;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.way_rd = 1'b1;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                o_cmd.way_chk = 1'b1;
                if (i_sts.match || i_sts.last) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_DECIDE: begin
                o_cmd.cnt_clr = 1'b1;
                if (i_sts.hit || i_sts.can_create) begin
                    n_state = S_LRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_LRD: begin
                o_cmd.lv_rd = 1'b1;
                n_state = S_LCHK;
            end
            S_LCHK: begin
                o_cmd.lv_chk = 1'b1;
                if (!i_sts.last) begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_LRD;
                end else if (i_sts.make) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_FIN;
            end
            S_DRD: begin
                o_cmd.del_rd = 1'b1;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.del_chk = 1'b1;
                if (i_sts.match) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_LRD;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> rtl/majority_node_structural_hash.sv
// Top level of the majority node structural hash block.
// Joins the controller and the datapath; depends on mnsh_pkg, mnsh_ctrl, mnsh_datapath.
//
// After reset the block sweeps both memories once, max(BUCKETS*WAYS, MAX_NODES)
// addresses (4096 by default), before it takes a request. A lookup or create runs
// 3 key multiply steps, 27 steps of the bit-serial modulo, a read and a check per
// way searched, one decision step, a read and a check per level read, the insert
// when one is made and the load of the result. A delete scans the bucket memory
// in order, one entry at a time through the single read port, up to BUCKETS*WAYS
// entries. Trivial requests skip the hash and the bucket search. The block returns
// to idle before the next request is taken. One request is in work at a time; the
// result register lets the next request enter while a result waits to be taken.
module majority_node_structural_hash #(
    parameter int MAX_NODES = mnsh_pkg::MAX_NODES_DEF,
    parameter int BUCKETS   = mnsh_pkg::BUCKETS_DEF,
    parameter int WAYS      = mnsh_pkg::WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // id_a[11:0], neg_a, id_b, neg_b, id_c, neg_c, victim_id, zero fill.
    input  logic [55:0] s_axis_tdata,
    // req_type[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_id[11:0], out_neg, out_level, stored_count, zero fill.
    output logic [39:0] m_axis_tdata,
    // status[2:0].
    output logic [2:0]  m_axis_tuser
);
    mnsh_pkg::t_cmd w_cmd;
    mnsh_pkg::t_sts w_sts;
    logic [mnsh_pkg::ID_W-1:0]   w_id;
    logic                        w_neg;
    logic [mnsh_pkg::LV_W-1:0]   w_lv;
    logic [mnsh_pkg::OCNT_W-1:0] w_cnt;

    mnsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mnsh_datapath #(
        .MAX_NODES (MAX_NODES),
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (s_axis_tuser),
        .i_id_a         (s_axis_tdata[11:0]),
        .i_neg_a        (s_axis_tdata[12]),
        .i_id_b         (s_axis_tdata[24:13]),
        .i_neg_b        (s_axis_tdata[25]),
        .i_id_c         (s_axis_tdata[37:26]),
        .i_neg_c        (s_axis_tdata[38]),
        .i_victim_id    (s_axis_tdata[50:39]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_status       (m_axis_tuser),
        .o_out_id       (w_id),
        .o_out_neg      (w_neg),
        .o_out_level    (w_lv),
        .o_stored_count (w_cnt)
    );

    assign s_axis_tready = w_cmd.ready;
    assign m_axis_tdata  = {2'b00, w_cnt, w_lv, w_neg, w_id};
endmodule
